// ===== sv/outage_logger_window_stats_core_macros.svh =====
// assertion macros for the outage logger window statistics core
// used by the top level only, no other dependencies
`ifndef OUTAGE_LOGGER_WINDOW_STATS_CORE_MACROS_SVH
`define OUTAGE_LOGGER_WINDOW_STATS_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define OWS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define OWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ows_pkg.sv =====
// shared types and constants for the outage logger window statistics core
// no dependencies
`default_nettype none

package ows_pkg;

   // field widths
   localparam int TIME_W    = 48;
   localparam int WIN_SEC_W = 29;
   localparam int WIN_US_W  = 49;
   localparam int COUNT_W   = 8;
   localparam int SECS_W    = 31;
   // saturating duration sum, always kept at or below SUM_SAT
   localparam int SUM_W     = 51;
   // wide enough for one million
   localparam int REM_W     = 20;

   localparam int DEF_RECORD_CAPACITY = 128;

   // seconds converter: sum / 10^6 = (sum >> 6) / 15625, and the division by 15625 is a
   // multiply by ceil(2^59 / 15625) keeping product bits from 59 up
   localparam int DIV_PRE_SHIFT = 6;
   localparam int DIV_X_W       = SUM_W - DIV_PRE_SHIFT;
   localparam int RECIP_W       = 46;
   localparam int RECIP_SHIFT   = 59;
   localparam int ACC_W         = DIV_X_W + RECIP_W;
   // one 32 by 32 partial product per cycle
   localparam int DIV_STEPS     = 4;
   localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(64'd36893488147420);

   localparam logic [REM_W-1:0]     US_PER_SECOND = REM_W'(1000000);
   // smallest sum whose whole seconds exceed the 31-bit maximum
   localparam logic [SUM_W-1:0]     SUM_SAT       = SUM_W'(64'd2147483648000000);
   localparam logic [COUNT_W-1:0]   COUNT_MAX     = '1;
   localparam logic [SECS_W-1:0]    SECS_MAX      = '1;
   localparam logic [WIN_SEC_W-1:0] WINDOW_RESET  = WIN_SEC_W'(604800);

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_WINDOW = 1'b0;

   typedef struct packed {
      logic              link_up;
      logic [TIME_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic               link_up_out;
      logic [COUNT_W-1:0] outage_count;
      logic [SECS_W-1:0]  outage_seconds;
   } rsp_type;

   // one stored outage
   typedef struct packed {
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] duration;
   } rec_type;

   // running totals that walk along the cell row
   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
   } tok_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_LAUNCH,
      ST_SCAN,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/outage_logger_window_stats_core.sv =====
// Outage logger with look-back window statistics, top level. Depends on ows_pkg,
// ows_cell, ows_sec_div and the macros header.
//
// Each request is one link probe (level and microsecond time). A falling edge
// notes the outage start; a rising edge appends (start, duration) to a log of
// RECORD_CAPACITY records that fills and then stops. Every request gives one
// response: the level echoed, and count and whole-second total of the records
// whose start lies less than window_seconds before the probe time, or after it.
// Channels: req_ and rsp_ valid/ready, window_seconds written over the APB port.
// One request is in work at a time. After acceptance the block updates the log,
// launches the totals, lets them walk the row of record cells one cell per cycle,
// turns the microsecond sum into seconds with a reciprocal multiply and registers
// the response; only then is the next request taken.
// The response register holds a finished response while the next request is
// taken; a stalled receiver only holds the block once a second response is ready.
// Reset empties the log, clears the pending start, marks the link as up and sets
// the window to one week.
`default_nettype none
`include "outage_logger_window_stats_core_macros.svh"

module outage_logger_window_stats_core
   import ows_pkg::*;
#(
   parameter int RECORD_CAPACITY = DEF_RECORD_CAPACITY
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   localparam int CNT_W = $clog2(RECORD_CAPACITY + 1);

   state_type state_ff, state_in;

   logic [WIN_SEC_W-1:0] window_seconds_ff;
   logic [WIN_US_W-1:0]  window_us_ff, window_us_in;
   req_type              req_ff, req_in;
   logic                 previous_up_ff, previous_up_in;
   logic [TIME_W-1:0]    pending_start_ff, pending_start_in;
   logic [CNT_W-1:0]     record_count_ff, record_count_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic    rec_shift;
   logic    launch;
   logic    div_start;
   logic    div_done;
   logic [SECS_W-1:0] div_secs;
   rec_type new_rec;

   rec_type rec_chain [RECORD_CAPACITY+1];
   tok_type tok_chain [RECORD_CAPACITY+1];

   // register port, always ready
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_seconds_ff <= WINDOW_RESET;
      end else if (psel && penable && pwrite && pready && paddr[2] == CSR_IDX_WINDOW) begin
         window_seconds_ff <= pwdata[WIN_SEC_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_IDX_WINDOW) begin
         prdata = CSR_DATA_W'(window_seconds_ff);
      end else begin
         prdata = '0;
      end
   end

   // new record from the pending start and the probe time
   always_comb begin
      new_rec.start = pending_start_ff;
      if (req_ff.time_us >= pending_start_ff) begin
         new_rec.duration = req_ff.time_us - pending_start_ff;
      end else begin
         new_rec.duration = '0;
      end
   end

   // sequencer: next state, log update and response hand-off
   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      previous_up_in   = previous_up_ff;
      pending_start_in = pending_start_ff;
      record_count_in  = record_count_ff;
      window_us_in     = window_us_ff;
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      req_ready        = 1'b0;
      rec_shift        = 1'b0;
      launch           = 1'b0;
      div_start        = 1'b0;

      // response taken by the receiver
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            // edge tracking; a pending start of zero is never logged
            if (req_ff.link_up) begin
               if (!previous_up_ff) begin
                  if (pending_start_ff != '0 &&
                      record_count_ff < CNT_W'(RECORD_CAPACITY)) begin
                     rec_shift       = 1'b1;
                     record_count_in = record_count_ff + CNT_W'(1);
                  end
                  pending_start_in = '0;
               end
            end else if (previous_up_ff) begin
               pending_start_in = req_ff.time_us;
            end
            previous_up_in = req_ff.link_up;
            window_us_in   = window_seconds_ff * US_PER_SECOND;
            state_in       = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // totals leave the row; the converter takes the sum straight from the last cell
            if (tok_chain[RECORD_CAPACITY].active) begin
               count_in  = tok_chain[RECORD_CAPACITY].count;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.link_up_out    = req_ff.link_up;
               rsp_data_in.outage_count   = count_ff;
               rsp_data_in.outage_seconds = div_secs;
               state_in                   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and log state
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_up_ff   <= 1'b1;
         pending_start_ff <= '0;
         record_count_ff  <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         previous_up_ff   <= previous_up_in;
         pending_start_ff <= pending_start_in;
         record_count_ff  <= record_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      window_us_ff <= window_us_in;
      count_ff     <= count_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // head of the cell row
   assign rec_chain[0]        = new_rec;
   assign tok_chain[0].active = launch;
   assign tok_chain[0].count  = '0;
   assign tok_chain[0].sum    = '0;

   // row of record cells, newest record in the first cell
   for (genvar i = 0; i < RECORD_CAPACITY; i++) begin : g_cell
      ows_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .rec_shift (rec_shift),
         .rec_valid (record_count_ff > CNT_W'(i)),
         .rec_in    (rec_chain[i]),
         .rec_out   (rec_chain[i+1]),
         .tok_in    (tok_chain[i]),
         .tok_out   (tok_chain[i+1]),
         .now       (req_ff.time_us),
         .window_us (window_us_ff)
      );
   end

   // microseconds to seconds
   ows_sec_div u_sec_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sum_us (tok_chain[RECORD_CAPACITY].sum),
      .done   (div_done),
      .secs   (div_secs)
   );

   // checks
   `OWS_ASSERT_NOW(a_log_bound, 1'b1, record_count_ff <= CNT_W'(RECORD_CAPACITY),
      "record count beyond log capacity")
   `OWS_ASSERT_NOW(a_tok_in_scan, tok_chain[RECORD_CAPACITY].active, state_ff == ST_SCAN,
      "totals left the cell row outside the scan")
   `OWS_ASSERT_NEXT(a_log_only_on_edge, state_ff != ST_LOG, $stable(record_count_ff),
      "record count changed outside the log update")

endmodule

`default_nettype wire

// ===== sv/ows_cell.sv =====
// one record cell of the outage log row: holds a record and adds it to the passing totals
// depends on ows_pkg
`default_nettype none

module ows_cell
   import ows_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rec_shift,
   input  wire logic                rec_valid,
   input  wire rec_type             rec_in,
   output rec_type                  rec_out,
   input  wire tok_type             tok_in,
   output tok_type                  tok_out,
   input  wire logic [TIME_W-1:0]   now,
   input  wire logic [WIN_US_W-1:0] window_us
);

   rec_type rec_ff;
   tok_type tok_ff;
   tok_type tok_in_next;

   logic [TIME_W:0]  age;
   logic             hit;
   logic [SUM_W:0]   sum_wide;

   // record storage, shifted along on each append
   always_ff @(posedge clock) begin
      if (rec_shift) begin
         rec_ff <= rec_in;
      end
   end

   // window test: start in the future, or age shorter than the window
   always_comb begin
      age      = {1'b0, now} - {1'b0, rec_ff.start};
      hit      = rec_valid && (age[TIME_W] || ({1'b0, age[TIME_W-1:0]} < window_us));
      sum_wide = {1'b0, tok_in.sum} + (SUM_W+1)'(rec_ff.duration);

      tok_in_next = tok_in;
      if (hit) begin
         if (tok_in.count != COUNT_MAX) begin
            tok_in_next.count = tok_in.count + COUNT_W'(1);
         end
         if (sum_wide >= (SUM_W+1)'(SUM_SAT)) begin
            tok_in_next.sum = SUM_SAT;
         end else begin
            tok_in_next.sum = sum_wide[SUM_W-1:0];
         end
      end
   end

   // hand the totals to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign rec_out = rec_ff;
   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== sv/ows_sec_div.sv =====
// microseconds to whole seconds converter, reciprocal multiply from partial products, saturating
// depends on ows_pkg
`default_nettype none

module ows_sec_div
   import ows_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [SUM_W-1:0] sum_us,
   output logic                  done,
   output logic [SECS_W-1:0]     secs
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               sat_ff, sat_in;
   logic [DIV_X_W-1:0] x_ff, x_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        product;
   logic [ACC_W-1:0]   shifted;

   // the 45 by 46 bit product is built from four 32 by 32 partial products, one a cycle
   always_comb begin
      x_in    = x_ff;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sat_in  = sat_ff;

      // low or high half of the dividend against low or high half of the reciprocal
      mul_a   = step_ff[1] ? 32'(x_ff[DIV_X_W-1:32]) : x_ff[31:0];
      mul_b   = step_ff[0] ? 32'(RECIP_MUL[RECIP_W-1:32]) : RECIP_MUL[31:0];
      product = mul_a * mul_b;

      case (step_ff)
         STEP_W'(0): shifted = ACC_W'(product);
         STEP_W'(1),
         STEP_W'(2): shifted = ACC_W'(product) << 32;
         default:    shifted = ACC_W'(product) << 64;
      endcase

      if (start) begin
         x_in    = sum_us[SUM_W-1:DIV_PRE_SHIFT];
         acc_in  = '0;
         sat_in  = (sum_us >= SUM_SAT);
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + shifted;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign secs = sat_ff ? SECS_MAX : acc_ff[RECIP_SHIFT +: SECS_W];

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench for the outage logger window statistics core
// needs ows_pkg and outage_logger_window_stats_core, nothing else
// probes go through a predicted outage log; every response is checked field by field
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ows_pkg::*;

   localparam int LOG_DEPTH = DEF_RECORD_CAPACITY;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int PHASE_PROBES = 150;
   localparam int PHASE_COUNT = 9;
   localparam logic [63:0] US_SECOND = 64'd1000000;
   localparam logic [63:0] SECONDS_CAP = 64'd2147483647;
   localparam logic [63:0] TIME_MASK = 64'hFFFF_FFFF_FFFF;
   localparam logic [TIME_W-1:0] TIME_TOP = '1;
   localparam logic [CSR_ADDR_W-1:0] WINDOW_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_WINDOW));

   // block ports
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // predicted state of the block
   logic [WIN_SEC_W-1:0] window_cfg = WINDOW_RESET;
   logic link_was_up = 1'b1;
   logic [63:0] outage_begin = '0;
   int log_fill = 0;
   logic [63:0] log_start [LOG_DEPTH];
   logic [63:0] log_length [LOG_DEPTH];

   // traffic bookkeeping
   req_type probe_queue [$];
   rsp_type stats_expected [$];
   rsp_type stats_want;
   int mismatches = 0;
   int stats_seen = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int hold_left = 0;
   int stall_left = 0;
   bit held_once = 1'b0;
   bit quiet = 1'b0;
   logic [63:0] gen_time = '0;
   logic gen_up = 1'b1;
   logic [CSR_DATA_W-1:0] window_plan [PHASE_COUNT] =
      '{604800, 1, 30, 300, 3600, 281474976, 0, 536870911, 0};

   outage_logger_window_stats_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // edge tracking, log append and window statistics for one probe
   function automatic rsp_type predict_window_stats(req_type p);
      logic [63:0] now;
      logic [63:0] win_us;
      logic [63:0] total;
      logic [63:0] secs;
      int hits;
      rsp_type res;
      now = {16'd0, p.time_us};
      total = '0;
      hits = 0;
      if (p.link_up) begin
         if (!link_was_up && outage_begin != 0) begin
            if (log_fill < LOG_DEPTH) begin
               log_start[log_fill] = outage_begin;
               log_length[log_fill] = (now >= outage_begin) ? now - outage_begin : 64'd0;
               log_fill++;
            end
            outage_begin = '0;
         end
      end else if (link_was_up) begin
         outage_begin = now;
      end
      link_was_up = p.link_up;
      win_us = 64'(window_cfg) * US_SECOND;
      for (int i = 0; i < log_fill; i++) begin
         if (log_start[i] > now || (now - log_start[i]) < win_us) begin
            hits++;
            total += log_length[i];
         end
      end
      secs = total / US_SECOND;
      if (secs > SECONDS_CAP) secs = SECONDS_CAP;
      if (hits > 255) hits = 255;
      res.link_up_out = p.link_up;
      res.outage_count = hits[COUNT_W-1:0];
      res.outage_seconds = secs[SECS_W-1:0];
      return res;
   endfunction

   // idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type probe(logic up, logic [TIME_W-1:0] t);
      req_type p;
      p.link_up = up;
      p.time_us = t;
      return p;
   endfunction

   // mostly forward-moving probe times with the odd jump, step back or stray value
   function automatic req_type random_probe();
      int r;
      logic [63:0] step;
      req_type p;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 25) gen_up = !gen_up;
      if (r < 1) begin
         step = {$urandom(), $urandom()};
         return probe(gen_up, step[TIME_W-1:0]);
      end
      if (r < 5) begin
         step = 64'($urandom_range(0, 50_000_000));
         gen_time = (gen_time > step) ? gen_time - step : 64'd0;
      end else if (r < 10) begin
         gen_time += 64'($urandom()) << $urandom_range(0, 6);
      end else if (r < 60) begin
         gen_time += 64'($urandom_range(0, 2_000_000));
      end else begin
         gen_time += 64'($urandom_range(0, 30_000_000));
      end
      gen_time &= TIME_MASK;
      return probe(gen_up, gen_time[TIME_W-1:0]);
   endfunction

   // sampled mid-cycle so the driver's updates at the rising edge are already seen
   task automatic wait_drained();
      do @(negedge clock);
      while (probe_queue.size() != 0 || req_valid || stats_expected.size() != 0);
   endtask

   // write the window register, then read it back
   task automatic program_window(input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= WINDOW_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      window_cfg = value[WIN_SEC_W-1:0];
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      if (prdata[WIN_SEC_W-1:0] !== value[WIN_SEC_W-1:0]) begin
         mismatches++;
         $display("%0t window read back expected %0d actual %0d",
                  $time, value[WIN_SEC_W-1:0], prdata[WIN_SEC_W-1:0]);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // request driver: presents queued probes, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) stats_expected.push_back(predict_window_stats(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (probe_queue.size() > 0) begin
               req_data <= probe_queue.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (stats_expected.size() == 0) begin
               mismatches++;
               $display("%0t unexpected response expected none actual %p", $time, rsp_data);
            end else begin
               stats_want = stats_expected.pop_front();
               if (rsp_data.link_up_out !== stats_want.link_up_out) begin
                  mismatches++;
                  $display("%0t link_up_out expected %0d actual %0d",
                           $time, stats_want.link_up_out, rsp_data.link_up_out);
               end
               if (rsp_data.outage_count !== stats_want.outage_count) begin
                  mismatches++;
                  $display("%0t outage_count expected %0d actual %0d",
                           $time, stats_want.outage_count, rsp_data.outage_count);
               end
               if (rsp_data.outage_seconds !== stats_want.outage_seconds) begin
                  mismatches++;
                  $display("%0t outage_seconds expected %0d actual %0d",
                           $time, stats_want.outage_seconds, rsp_data.outage_seconds);
               end
            end
            stats_seen++;
         end
         if (!held_once && stats_seen == 300) begin
            held_once = 1'b1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // field extremes, a falling edge at time zero, a plain outage, time stepping back
      probe_queue.push_back(probe(1'b1, '0));
      probe_queue.push_back(probe(1'b0, '0));
      probe_queue.push_back(probe(1'b1, 48'd5));
      probe_queue.push_back(probe(1'b0, 48'd1_000_000));
      probe_queue.push_back(probe(1'b0, 48'd2_000_000));
      probe_queue.push_back(probe(1'b1, 48'd61_000_000));
      probe_queue.push_back(probe(1'b0, 48'd70_000_000));
      probe_queue.push_back(probe(1'b1, 48'd65_000_000));
      probe_queue.push_back(probe(1'b1, TIME_TOP));
      // huge outages that drive the seconds total into saturation
      for (int i = 0; i < 8; i++) begin
         probe_queue.push_back(probe(1'b0, 48'd1));
         probe_queue.push_back(probe(1'b1, TIME_TOP));
      end
      // every record now starts after the current time
      probe_queue.push_back(probe(1'b1, '0));

      // random phases, one window setting each; the log fills part way through
      window_plan[PHASE_COUNT-1] = $urandom_range(1, 281474976);
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_drained();
         program_window(window_plan[ph]);
         quiet = (ph == 2 || ph == 6);
         gen_time = 64'(ph + 1) * 64'd1_000_000_000_000 + 64'($urandom_range(0, 1_000_000_000));
         for (int n = 0; n < PHASE_PROBES; n++) probe_queue.push_back(random_probe());
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && stats_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
